@@ sv/fsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_pkg: shared types for the two-stream frame sync interpolator
// Controller states, register indexes and the command / status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package fsi_pkg;

  // Configuration register index width and codes
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM1_START = 2'd0,
    REG_CAM1_END   = 2'd1,
    REG_CAM2_START = 2'd2,
    REG_CAM2_END   = 2'd3
  } cfg_reg_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic mul_load;     // register the interpolation product
    logic div_init;     // load the divider from the product
    logic div_step;     // run one divider iteration
    logic fast_commit;  // commit an idle, first or finishing word
    logic slow_commit;  // commit an interpolated step
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_normal;   // the offered word needs the interpolation path
    logic out_busy;     // output register holds a word that is not taken
    logic div_last;     // this divider iteration is the final one
  } dp_status_t;

endpackage

@@ sv/fsi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_div: serial restoring divider
// Divides a 2*W-bit dividend by a W-bit divisor one quotient bit per cycle
// while step_i is high. The upper half of the dividend must be below the
// divisor, so the quotient fits W bits and W iterations finish the job.
// ----------------------------------------------------------------------------
module fsi_div #(
  parameter int unsigned W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           init_i,
  input  logic           step_i,
  input  logic [2*W-1:0] dividend_i,
  input  logic [W-1:0]   divisor_i,
  output logic [W-1:0]   quotient_o,
  output logic [W-1:0]   remainder_o,
  output logic           last_o
);

  localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = (trial >= {1'b0, divisor_i});
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (init_i) begin
      rem_d = dividend_i[2*W-1:W];
      quo_d = dividend_i[W-1:0];
      cnt_d = '0;
    end else if (step_i) begin
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // Iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign last_o      = step_i && (cnt_q == CNT_W'(W - 1));

endmodule

@@ sv/fsi_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_datapath: registers, span logic, interpolation and output word
// Holds the frame range registers and the sync state, forms the product
// (k-1)*lenL, divides it by lenS, rounds half up and builds the result word.
// ----------------------------------------------------------------------------
module fsi_datapath #(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [fsi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FRAME_BITS-1:0]        cfg_data_i,
  // request payload
  input  logic                         advance_i,
  // control
  input  fsi_pkg::dp_cmd_t             cmd_i,
  output fsi_pkg::dp_status_t          status_o,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [FRAME_BITS:0]          sync_index_o,
  output logic [FRAME_BITS-1:0]        cam1_pull_o,
  output logic [FRAME_BITS-1:0]        cam2_pull_o,
  output logic [FRAME_BITS-1:0]        cam1_position_o,
  output logic [FRAME_BITS-1:0]        cam2_position_o,
  output logic                         cam1_is_longer_o,
  output logic                         finished_o
);

  localparam int unsigned FB = FRAME_BITS;

  // Configuration registers
  logic [FB-1:0] cam1_start_q, cam1_end_q, cam2_start_q, cam2_end_q;

  // Sync state
  logic [FB:0]   step_q, step_d;
  logic [FB-1:0] short_pos_q, short_pos_d;
  logic [FB-1:0] long_pos_q, long_pos_d;
  logic          end_q, end_d;

  // Span and role decision
  logic [FB-1:0] len1, len2, len_l, len_s, start_l, start_s;
  logic          one_long;
  logic [FB:0]   len_s_p1;
  logic          step_zero, fin_cond;

  // Interpolation
  logic [2*FB-1:0] prod_q;
  logic [FB-1:0]   quo, rem, half_gap, q_rnd, target;
  logic            round_up, div_last;

  // Step results
  logic [FB-1:0] pull_l, pull_s;
  logic          commit;

  // Output register
  logic          out_valid_q;
  logic [FB:0]   sync_index_q;
  logic [FB-1:0] cam1_pull_q, cam2_pull_q, cam1_pos_q, cam2_pos_q;
  logic          cam1_longer_q, finished_q;

  // Write the range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam1_start_q <= '0;
      cam1_end_q   <= '0;
      cam2_start_q <= '0;
      cam2_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (fsi_pkg::cfg_reg_e'(cfg_idx_i))
        fsi_pkg::REG_CAM1_START: cam1_start_q <= cfg_data_i;
        fsi_pkg::REG_CAM1_END:   cam1_end_q   <= cfg_data_i;
        fsi_pkg::REG_CAM2_START: cam2_start_q <= cfg_data_i;
        fsi_pkg::REG_CAM2_END:   cam2_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Spans (an end below its start counts as the start) and long/short roles
  always_comb begin
    len1      = (cam1_end_q > cam1_start_q) ? (cam1_end_q - cam1_start_q) : '0;
    len2      = (cam2_end_q > cam2_start_q) ? (cam2_end_q - cam2_start_q) : '0;
    one_long  = (len1 >= len2);
    len_l     = one_long ? len1 : len2;
    len_s     = one_long ? len2 : len1;
    start_l   = one_long ? cam1_start_q : cam2_start_q;
    start_s   = one_long ? cam2_start_q : cam1_start_q;
    len_s_p1  = {1'b0, len_s} + (FB+1)'(1);
    step_zero = (step_q == '0);
    fin_cond  = (step_q >= len_s_p1);
  end

  // Classify the offered word
  assign status_o.req_normal = advance_i && !end_q && !step_zero && !fin_cond;
  assign status_o.out_busy   = out_valid_q && out_stall_i;
  assign status_o.div_last   = div_last;

  // Product (k-1)*lenL; k-1 equals the old step, which is at most lenS here
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= step_q[FB-1:0] * len_l;
    end
  end

  fsi_div #(
    .W (FB)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (cmd_i.div_init),
    .step_i      (cmd_i.div_step),
    .dividend_i  (prod_q),
    .divisor_i   (len_s),
    .quotient_o  (quo),
    .remainder_o (rem),
    .last_o      (div_last)
  );

  // Round half up and place the long stream
  always_comb begin
    half_gap = len_s - rem;
    round_up = (rem >= half_gap);
    q_rnd    = quo + FB'(round_up);
    target   = start_l + q_rnd;
  end

  // Next sync state and pulls
  always_comb begin
    step_d      = step_q;
    short_pos_d = short_pos_q;
    long_pos_d  = long_pos_q;
    end_d       = end_q;
    pull_l      = '0;
    pull_s      = '0;
    if (cmd_i.fast_commit && advance_i && !end_q) begin
      if (step_zero) begin
        step_d      = (FB+1)'(1);
        long_pos_d  = start_l;
        short_pos_d = start_s;
        pull_l      = start_l;
        pull_s      = start_s;
      end else begin
        end_d = 1'b1;
      end
    end else if (cmd_i.slow_commit) begin
      step_d      = step_q + (FB+1)'(1);
      short_pos_d = short_pos_q + FB'(1);
      long_pos_d  = target;
      pull_s      = FB'(1);
      pull_l      = (target > long_pos_q) ? (target - long_pos_q) : '0;
    end
  end

  assign commit = cmd_i.fast_commit || cmd_i.slow_commit;

  // Sync state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      short_pos_q <= '0;
      long_pos_q  <= '0;
      end_q       <= 1'b0;
    end else if (commit) begin
      step_q      <= step_d;
      short_pos_q <= short_pos_d;
      long_pos_q  <= long_pos_d;
      end_q       <= end_d;
    end
  end

  // Output word valid: set on load, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload, mapped back to the two streams
  always_ff @(posedge clk_i) begin
    if (commit) begin
      sync_index_q  <= step_d;
      cam1_pull_q   <= one_long ? pull_l : pull_s;
      cam2_pull_q   <= one_long ? pull_s : pull_l;
      cam1_pos_q    <= one_long ? long_pos_d : short_pos_d;
      cam2_pos_q    <= one_long ? short_pos_d : long_pos_d;
      cam1_longer_q <= one_long;
      finished_q    <= end_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sync_index_o     = sync_index_q;
  assign cam1_pull_o      = cam1_pull_q;
  assign cam2_pull_o      = cam2_pull_q;
  assign cam1_position_o  = cam1_pos_q;
  assign cam2_position_o  = cam2_pos_q;
  assign cam1_is_longer_o = cam1_longer_q;
  assign finished_o       = finished_q;

endmodule

@@ sv/fsi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_ctrl: sequencing state machine
// Accepts request words, commits simple ones at once and walks interpolated
// steps through multiply, serial divide and commit.
// ----------------------------------------------------------------------------
module fsi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fsi_pkg::dp_status_t status_i,
  output fsi_pkg::dp_cmd_t    cmd_o
);

  fsi_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      fsi_pkg::ST_IDLE: begin
        in_stall_o = status_i.out_busy;
        if (in_valid_i && !status_i.out_busy) begin
          if (status_i.req_normal) begin
            cmd_o.mul_load = 1'b1;
            state_d        = fsi_pkg::ST_MUL;
          end else begin
            cmd_o.fast_commit = 1'b1;
          end
        end
      end
      fsi_pkg::ST_MUL: begin
        cmd_o.div_init = 1'b1;
        state_d        = fsi_pkg::ST_DIV;
      end
      fsi_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fsi_pkg::ST_FIN;
        end
      end
      fsi_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.slow_commit = 1'b1;
          state_d           = fsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fsi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/two_stream_frame_sync_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stream_frame_sync_interpolator: frame alignment of two streams
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Each request word gives exactly one result word. Idle words, the first
// step and the finishing step are committed in the accept cycle, so the
// result is valid in the next cycle. An interpolated step registers the
// product when accepted, loads the divider, runs FRAME_BITS iterations of
// the one-bit-per-cycle divider and commits once the output register is
// free; only then is the next request word taken. The request side stalls
// while a step is in progress or while an untaken result blocks the output
// register. Write the range registers only while no step is in progress.
module two_stream_frame_sync_interpolator #(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [fsi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FRAME_BITS-1:0]         cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          advance_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [FRAME_BITS:0]           sync_index_o,
  output logic [FRAME_BITS-1:0]         cam1_pull_o,
  output logic [FRAME_BITS-1:0]         cam2_pull_o,
  output logic [FRAME_BITS-1:0]         cam1_position_o,
  output logic [FRAME_BITS-1:0]         cam2_position_o,
  output logic                          cam1_is_longer_o,
  output logic                          finished_o
);

  fsi_pkg::dp_cmd_t    cmd;
  fsi_pkg::dp_status_t status;

  fsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fsi_datapath #(
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .advance_i        (advance_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sync_index_o     (sync_index_o),
    .cam1_pull_o      (cam1_pull_o),
    .cam2_pull_o      (cam2_pull_o),
    .cam1_position_o  (cam1_position_o),
    .cam2_position_o  (cam2_position_o),
    .cam1_is_longer_o (cam1_is_longer_o),
    .finished_o       (finished_o)
  );

endmodule

@@ sim/two_stream_frame_sync_interpolator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stream_frame_sync_interpolator_test: self-checking bench for the sync
// interpolator
// A queue-fed driver offers request words, a clocked monitor takes the result
// words, and an in-bench model of the step logic predicts every result. The
// directed opening covers reset ranges, huge first pulls, exact half rounding
// and the widest ratio. Random phases then follow, each with freshly written
// ranges that keep the run alive. The close forces the finish boundary and
// the sticky end state, with both ends written below their starts.
// ----------------------------------------------------------------------------
module two_stream_frame_sync_interpolator_test;

  localparam int unsigned FB = 16;
  localparam int unsigned FRAME_MAX = (1 << FB) - 1;

  typedef struct packed {
    logic [FB:0]   sync_index;
    logic [FB-1:0] cam1_pull;
    logic [FB-1:0] cam2_pull;
    logic [FB-1:0] cam1_position;
    logic [FB-1:0] cam2_position;
    logic          cam1_is_longer;
    logic          finished;
  } sync_word_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [fsi_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [FB-1:0]                 cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          advance = 1'b0;
  logic                          out_stall = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic [FB:0]                   sync_index_o;
  logic [FB-1:0]                 cam1_pull_o, cam2_pull_o, cam1_position_o, cam2_position_o;
  logic                          cam1_is_longer_o, finished_o;

  // Step model state and range registers
  logic [FB-1:0] frame_range [4] = '{default: '0};
  logic [FB:0]   step_count = '0;
  logic [FB-1:0] short_frame = '0;
  logic [FB-1:0] long_frame = '0;
  logic          sync_done = 1'b0;

  logic         pending_steps [$];
  sync_word_t   expected_words [$];
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  bit           quiet_phase = 1'b0;
  bit           mismatch_seen = 1'b0;

  two_stream_frame_sync_interpolator #(
    .FRAME_BITS(FB)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .advance_i       (advance),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .sync_index_o    (sync_index_o),
    .cam1_pull_o     (cam1_pull_o),
    .cam2_pull_o     (cam2_pull_o),
    .cam1_position_o (cam1_position_o),
    .cam2_position_o (cam2_position_o),
    .cam1_is_longer_o(cam1_is_longer_o),
    .finished_o      (finished_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Wait cycles for one word; none at all in quiet phases
  function automatic int unsigned draw_wait();
    return quiet_phase ? 0 : $urandom_range(0, 13);
  endfunction

  // Advance the step model by one request word and return its result word
  function automatic sync_word_t advance_sync(logic adv);
    sync_word_t      w;
    logic [FB-1:0]   len1, len2, start_l, start_s, len_l, len_s;
    logic [FB-1:0]   pull_l, pull_s, target;
    logic            cam1_long;
    longint unsigned prod, quo, rem;
    len1 = (frame_range[fsi_pkg::REG_CAM1_END] > frame_range[fsi_pkg::REG_CAM1_START]) ?
           frame_range[fsi_pkg::REG_CAM1_END] - frame_range[fsi_pkg::REG_CAM1_START] : '0;
    len2 = (frame_range[fsi_pkg::REG_CAM2_END] > frame_range[fsi_pkg::REG_CAM2_START]) ?
           frame_range[fsi_pkg::REG_CAM2_END] - frame_range[fsi_pkg::REG_CAM2_START] : '0;
    cam1_long = (len1 >= len2);
    start_l = cam1_long ? frame_range[fsi_pkg::REG_CAM1_START] :
                          frame_range[fsi_pkg::REG_CAM2_START];
    start_s = cam1_long ? frame_range[fsi_pkg::REG_CAM2_START] :
                          frame_range[fsi_pkg::REG_CAM1_START];
    len_l = cam1_long ? len1 : len2;
    len_s = cam1_long ? len2 : len1;
    pull_l = '0;
    pull_s = '0;
    if (adv && !sync_done) begin
      if (step_count == 0) begin
        // first step: jump both streams to their starts
        step_count = (FB+1)'(1);
        long_frame = start_l;
        short_frame = start_s;
        pull_l = start_l;
        pull_s = start_s;
      end else if (longint'(step_count) >= longint'(len_s) + 1) begin
        sync_done = 1'b1;
      end else begin
        // short stream moves one frame, long stream to the rounded target
        step_count = step_count + 1'b1;
        short_frame = short_frame + 1'b1;
        pull_s = FB'(1);
        prod = longint'(step_count - 1'b1) * longint'(len_l);
        quo = prod / len_s;
        rem = prod % len_s;
        if (rem >= len_s - rem) quo++;
        target = start_l + quo[FB-1:0];
        pull_l = (target > long_frame) ? target - long_frame : '0;
        long_frame = target;
      end
    end
    w.sync_index     = step_count;
    w.cam1_pull      = cam1_long ? pull_l : pull_s;
    w.cam2_pull      = cam1_long ? pull_s : pull_l;
    w.cam1_position  = cam1_long ? long_frame : short_frame;
    w.cam2_position  = cam1_long ? short_frame : long_frame;
    w.cam1_is_longer = cam1_long;
    w.finished       = sync_done;
    return w;
  endfunction

  // Request driver: hold each word until taken, then idle for its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      advance <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_words.push_back(advance_sync(advance));
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_steps.size() != 0) begin
          in_valid <= 1'b1;
          advance <= pending_steps.pop_front();
          gap_left <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [FB:0] exp_val, logic [FB:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s expected %0d got %0d", name, exp_val, got_val);
      mismatch_seen = 1'b1;
    end
  endtask

  // Result monitor: compare each taken word with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    sync_word_t  exp_word;
    int unsigned hold;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid_o && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no request pending");
          mismatch_seen = 1'b1;
        end else begin
          exp_word = expected_words.pop_front();
          check_field("sync_index", exp_word.sync_index, sync_index_o);
          check_field("cam1_pull", (FB+1)'(exp_word.cam1_pull), (FB+1)'(cam1_pull_o));
          check_field("cam2_pull", (FB+1)'(exp_word.cam2_pull), (FB+1)'(cam2_pull_o));
          check_field("cam1_position", (FB+1)'(exp_word.cam1_position),
                      (FB+1)'(cam1_position_o));
          check_field("cam2_position", (FB+1)'(exp_word.cam2_position),
                      (FB+1)'(cam2_position_o));
          check_field("cam1_is_longer", (FB+1)'(exp_word.cam1_is_longer),
                      (FB+1)'(cam1_is_longer_o));
          check_field("finished", (FB+1)'(exp_word.finished), (FB+1)'(finished_o));
        end
        hold = draw_wait();
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(fsi_pkg::cfg_reg_e idx, logic [FB-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    frame_range[idx] = value;
  endtask

  task automatic write_ranges(int unsigned s1, int unsigned e1, int unsigned s2,
                              int unsigned e2);
    write_reg(fsi_pkg::REG_CAM1_START, s1[FB-1:0]);
    write_reg(fsi_pkg::REG_CAM1_END, e1[FB-1:0]);
    write_reg(fsi_pkg::REG_CAM2_START, s2[FB-1:0]);
    write_reg(fsi_pkg::REG_CAM2_END, e2[FB-1:0]);
  endtask

  // Drain everything, then let the block settle before touching registers
  task automatic wait_idle();
    while (pending_steps.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (FB + 4) @(posedge clk_i);
  endtask

  // Queue n request words from the pattern, bit 0 first
  task automatic queue_steps(logic [31:0] pattern, int n);
    for (int i = 0; i < n; i++) pending_steps.push_back(pattern[i]);
    wait_idle();
  endtask

  // Pick random ranges whose short span outlasts the next n steps
  task automatic pick_ranges(int unsigned n);
    int unsigned lo, len_s, len_l, start_l, start_s;
    lo = step_count + n + 2;
    if ($urandom_range(0, 1)) len_s = lo + $urandom_range(0, 1500);
    else len_s = $urandom_range(lo, FRAME_MAX);
    case ($urandom_range(0, 3))
      0: len_l = len_s;
      1: len_l = FRAME_MAX;
      default: len_l = $urandom_range(len_s, FRAME_MAX);
    endcase
    start_l = $urandom_range(0, FRAME_MAX - len_l);
    start_s = $urandom_range(0, FRAME_MAX - len_s);
    if (len_l == len_s || $urandom_range(0, 1))
      write_ranges(start_l, start_l + len_l, start_s, start_s + len_s);
    else
      write_ranges(start_s, start_s + len_s, start_l, start_l + len_l);
  endtask

  initial begin
    int unsigned issued, n, len_s, len_l, s1, s2;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset ranges: idle words only, nothing moves
    queue_steps(32'h0, 2);

    // Stream two longer by 3/2: first step pulls near the top, odd steps round half up
    write_ranges(65500, 65530, 65490, FRAME_MAX);
    queue_steps(32'h7EE, 11);

    // Widest ratio: stream one spans the whole frame range
    write_ranges(0, FRAME_MAX, 0, 40);
    queue_steps(32'h3FF, 10);

    // Random phases with fresh ranges, quiet ones now and then
    issued = 0;
    while (issued < 1075) begin
      n = $urandom_range(15, 70);
      pick_ranges(n);
      quiet_phase = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) pending_steps.push_back($urandom_range(0, 99) < 85);
      wait_idle();
      issued += n;
    end
    quiet_phase = 1'b0;

    // Finish boundary: short span two steps ahead, then finish and stay done
    len_s = step_count + 2;
    len_l = $urandom_range(len_s + 1, FRAME_MAX);
    s1 = $urandom_range(0, FRAME_MAX - len_s);
    s2 = $urandom_range(0, FRAME_MAX - len_l);
    write_ranges(s1, s1 + len_s, s2, s2 + len_l);
    queue_steps(32'h37, 6);

    // Both ends below their starts: zero spans, stream one counts as longer
    write_ranges(32768, 1, FRAME_MAX, 0);
    queue_steps(32'hD, 4);

    repeat (40) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
